@@ src/udc_pkg.sv @@
// Package for the UDP datagram receive checker.
// Holds the shared types, constants and the one's-complement add helper.
// No dependencies.
package udc_pkg;

  // Widths of the interface fields.
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 17;

  // Protocol constants.
  localparam logic [WordW-1:0]  UdpProto  = 16'h0011;
  localparam logic [CountW-1:0] HdrLen    = 17'd8;
  localparam logic [CountW-1:0] CountMax  = 17'h1FFFF;
  localparam logic [WordW-1:0]  SumPassed = 16'hFFFF;

  // Header byte positions.
  localparam logic [CountW-1:0] IdxSportLo = 17'd1;
  localparam logic [CountW-1:0] IdxDportHi = 17'd2;
  localparam logic [CountW-1:0] IdxDportLo = 17'd3;
  localparam logic [CountW-1:0] IdxLenHi   = 17'd4;
  localparam logic [CountW-1:0] IdxLenLo   = 17'd5;
  localparam logic [CountW-1:0] IdxCsumHi  = 17'd6;
  localparam logic [CountW-1:0] IdxCsumLo  = 17'd7;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_ACCEPTED     = 2'd0,
    STAT_LEN_MISMATCH = 2'd1,
    STAT_NO_PAYLOAD   = 2'd2,
    STAT_CSUM_FAILED  = 2'd3
  } status_e;

  // One registered input byte with its precomputed pseudo-header sum.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last;
    logic [WordW-1:0] pseudo_sum;
  } in_item_t;

  // Datagram context handed to the verdict stage on the last byte.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [WordW-1:0]  sum;
    logic [ByteW-1:0]  pending;
    logic [WordW-1:0]  sport;
    logic [WordW-1:0]  dport;
    logic [WordW-1:0]  len_field;
    logic              csum_nz;
  } fin_rec_t;

  // One's-complement add with end-around carry.
  function automatic logic [WordW-1:0] ones_add(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

endpackage

@@ src/udc_in_stage.sv @@
// Input register of the UDP datagram receive checker.
// Depends on udc_pkg; folds the IPv4 addresses and protocol of the pseudo-header into a 16-bit sum on entry.
module udc_in_stage (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: data_byte[7:0], source_address[39:8], dest_address[71:40].
  input  logic [71:0]           s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  take_i,
  output logic                  valid_o,
  output udc_pkg::in_item_t     item_o
);

  logic                  valid_q;
  udc_pkg::in_item_t     item_q;
  udc_pkg::in_item_t     item_d;
  logic [18:0]           wide_sum;
  logic [16:0]           fold1;
  logic [15:0]           fold2;
  logic [31:0]           src_addr;
  logic [31:0]           dst_addr;

  // The register frees up whenever its item moves on.
  assign s_axis_tready = !valid_q || take_i;

  // Pseudo-header sum: both addresses and the protocol word, folded twice.
  assign src_addr = s_axis_tdata[39:8];
  assign dst_addr = s_axis_tdata[71:40];
  assign wide_sum = {3'b0, src_addr[31:16]} + {3'b0, src_addr[15:0]}
                  + {3'b0, dst_addr[31:16]} + {3'b0, dst_addr[15:0]}
                  + {3'b0, udc_pkg::UdpProto};
  assign fold1    = {1'b0, wide_sum[15:0]} + {14'b0, wide_sum[18:16]};
  assign fold2    = fold1[15:0] + {15'b0, fold1[16]};

  always_comb begin
    item_d.data_byte  = s_axis_tdata[7:0];
    item_d.last       = s_axis_tlast;
    item_d.pseudo_sum = fold2;
  end

  // Valid flag of the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      valid_q <= s_axis_tvalid;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ src/udc_accum.sv @@
// Per-byte state update of the UDP datagram receive checker.
// Depends on udc_pkg; keeps the byte count, running sum and header captures.
module udc_accum (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  udc_pkg::in_item_t     item_i,
  output logic                  take_o,
  input  logic                  fin_take_i,
  output logic                  fin_valid_o,
  output udc_pkg::fin_rec_t     fin_o
);

  logic [udc_pkg::CountW-1:0] count_q, count_d, count_inc;
  logic [udc_pkg::WordW-1:0]  sum_q, sum_d;
  logic [udc_pkg::ByteW-1:0]  pend_q, pend_d;
  logic [udc_pkg::WordW-1:0]  sport_q, sport_d;
  logic [udc_pkg::WordW-1:0]  dport_q, dport_d;
  logic [udc_pkg::WordW-1:0]  len_q, len_d;
  logic                       csum_nz_q, csum_nz_d;
  logic                       first;
  logic                       fin_valid_q;
  udc_pkg::fin_rec_t          fin_q;
  udc_pkg::fin_rec_t          fin_d;
  logic                       fin_load;
  logic [udc_pkg::ByteW-1:0]  b;

  // A byte is consumed when the result register can take a possible result.
  assign take_o   = in_valid_i && (!fin_valid_q || fin_take_i);
  assign fin_load = take_o && item_i.last;
  assign b        = item_i.data_byte;
  assign first    = (count_q == '0);

  // Next state of the datagram context for the byte in the input register.
  always_comb begin
    sport_d   = first ? {b, 8'h00} : sport_q;
    dport_d   = first ? '0 : dport_q;
    len_d     = first ? '0 : len_q;
    csum_nz_d = first ? 1'b0 : csum_nz_q;
    if (count_q == udc_pkg::IdxSportLo) sport_d = {sport_q[15:8], b};
    if (count_q == udc_pkg::IdxDportHi) dport_d = {b, dport_q[7:0]};
    if (count_q == udc_pkg::IdxDportLo) dport_d = {dport_q[15:8], b};
    if (count_q == udc_pkg::IdxLenHi)   len_d   = {b, len_q[7:0]};
    if (count_q == udc_pkg::IdxLenLo)   len_d   = {len_q[15:8], b};
    if ((count_q == udc_pkg::IdxCsumHi || count_q == udc_pkg::IdxCsumLo) && (b != '0)) begin
      csum_nz_d = 1'b1;
    end

    // Bytes pair up by count parity; the first byte seeds the pseudo-header sum.
    pend_d = count_q[0] ? pend_q : b;
    if (first) begin
      sum_d = item_i.pseudo_sum;
    end else if (count_q[0]) begin
      sum_d = udc_pkg::ones_add(sum_q, {pend_q, b});
    end else begin
      sum_d = sum_q;
    end

    count_inc = (count_q == udc_pkg::CountMax) ? count_q : count_q + 1'b1;
    count_d   = item_i.last ? '0 : count_inc;

    fin_d.count     = count_inc;
    fin_d.sum       = sum_d;
    fin_d.pending   = pend_d;
    fin_d.sport     = sport_d;
    fin_d.dport     = dport_d;
    fin_d.len_field = len_d;
    fin_d.csum_nz   = csum_nz_d;
  end

  // Control state: byte count within the datagram.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (take_o) begin
      count_q <= count_d;
    end
  end

  // Running sum and header captures.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      pend_q    <= '0;
      sport_q   <= '0;
      dport_q   <= '0;
      len_q     <= '0;
      csum_nz_q <= 1'b0;
    end else if (take_o) begin
      sum_q     <= sum_d;
      pend_q    <= pend_d;
      sport_q   <= sport_d;
      dport_q   <= dport_d;
      len_q     <= len_d;
      csum_nz_q <= csum_nz_d;
    end
  end

  // Context register for the verdict stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_load) begin
      fin_valid_q <= 1'b1;
    end else if (fin_take_i) begin
      fin_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_q <= fin_d;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

endmodule

@@ src/udc_verdict.sv @@
// Verdict and output register of the UDP datagram receive checker.
// Depends on udc_pkg; finishes the checksum and picks the status.
module udc_verdict (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  csum_en_i,
  input  logic                  fin_valid_i,
  input  udc_pkg::fin_rec_t     fin_i,
  output logic                  fin_take_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0 up: source_port[15:0], dest_port[31:16], payload_length[47:32].
  output logic [47:0]           m_axis_tdata,
  // Fields from bit 0 up: status[1:0].
  output logic [1:0]            m_axis_tuser
);

  logic                        out_valid_q;
  logic [47:0]                 data_q, data_d;
  udc_pkg::status_e            status_q, status_d;
  logic [udc_pkg::WordW-1:0]   sum_pad, sum_final;
  logic [udc_pkg::WordW-1:0]   plen;
  logic                        len_bad;

  assign fin_take_o = fin_valid_i && (!out_valid_q || m_axis_tready);

  // Pad an odd last byte, then add the pseudo-header length word.
  assign sum_pad   = fin_i.count[0]
                   ? udc_pkg::ones_add(fin_i.sum, {fin_i.pending, 8'h00}) : fin_i.sum;
  assign sum_final = udc_pkg::ones_add(sum_pad, fin_i.count[15:0]);

  assign len_bad = (fin_i.count < udc_pkg::HdrLen) || fin_i.count[16]
                || (fin_i.count[15:0] != fin_i.len_field);

  // Status priority: length, empty payload, checksum.
  always_comb begin
    plen = '0;
    if (len_bad) begin
      status_d = udc_pkg::STAT_LEN_MISMATCH;
    end else if (fin_i.count == udc_pkg::HdrLen) begin
      status_d = udc_pkg::STAT_NO_PAYLOAD;
    end else if (csum_en_i && fin_i.csum_nz && (sum_final != udc_pkg::SumPassed)) begin
      status_d = udc_pkg::STAT_CSUM_FAILED;
    end else begin
      status_d = udc_pkg::STAT_ACCEPTED;
      plen     = fin_i.count[15:0] - udc_pkg::HdrLen[15:0];
    end
    data_d = {plen, fin_i.dport, fin_i.sport};
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_take_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take_o) begin
      data_q   <= data_d;
      status_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = status_q;

  // An accepted datagram always carries payload; any other status reports none.
  a_accept_has_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == udc_pkg::STAT_ACCEPTED) |-> (data_q[47:32] != '0))
    else $error("accepted result with zero payload length");

  a_reject_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != udc_pkg::STAT_ACCEPTED) |-> (data_q[47:32] == '0))
    else $error("rejected result with nonzero payload length");

  a_context_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take_o |=> out_valid_q)
    else $error("context taken but no result registered");

endmodule

@@ src/udp_datagram_receive_checker.sv @@
// Top level of the UDP datagram receive checker.
// Depends on udc_pkg, udc_in_stage, udc_accum and udc_verdict.
//
// Usage: the slave stream carries one datagram byte per transfer, header first,
// with the IPv4 source and destination addresses alongside; they are used only
// on the first byte. tlast marks the final byte. For each datagram the master
// stream gives one transfer: tuser holds the status (accepted, length mismatch,
// no payload, checksum failed) and tdata the ports and the payload length.
// The pseudo-header and data checksum is verified when cfg_we_i has written a
// one (the reset value) and the header's checksum field is nonzero.
// Timing: one byte per cycle sustained while the master side keeps up. A byte
// moves through three registers (input, datagram context, output); the result
// of a datagram is valid on the master side once it reaches the output register.
// When the master side stalls, the output register holds its result and the
// earlier stages keep taking bytes until a second finished result is waiting;
// only then does s_axis_tready drop.
// Reset clears all counters and valid flags and sets checksum checking on.
// The user writes the configuration bit only with no datagram in flight; unenforced.
module udp_datagram_receive_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: data_byte[7:0], source_address[39:8], dest_address[71:40].
  input  logic [71:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: source_port[15:0], dest_port[31:16], payload_length[47:32].
  output logic [47:0] m_axis_tdata,
  // Fields from bit 0 up: status[1:0].
  output logic [1:0]  m_axis_tuser
);

  logic                   csum_en_q;
  logic                   in_valid;
  udc_pkg::in_item_t      in_item;
  logic                   take;
  logic                   fin_valid;
  udc_pkg::fin_rec_t      fin_rec;
  logic                   fin_take;

  // Checksum enable register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csum_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      csum_en_q <= cfg_wdata_i;
    end
  end

  udc_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .take_i        (take),
    .valid_o       (in_valid),
    .item_o        (in_item)
  );

  udc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .item_i      (in_item),
    .take_o      (take),
    .fin_take_i  (fin_take),
    .fin_valid_o (fin_valid),
    .fin_o       (fin_rec)
  );

  udc_verdict u_verdict (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .csum_en_i     (csum_en_q),
    .fin_valid_i   (fin_valid),
    .fin_i         (fin_rec),
    .fin_take_o    (fin_take),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

@@ verif/udc_verdicts_pkg.sv @@
// Verdict predictor and checker for the UDP datagram receive checker testbench.
// Rebuilds each datagram's status, ports and payload length from the byte transfers.
// Depends on udc_pkg for the status codes and protocol constants.
package udc_verdicts_pkg;
  import udc_pkg::*;

  // One predicted result transfer.
  typedef struct {
    status_e          status;
    logic [WordW-1:0] sport;
    logic [WordW-1:0] dport;
    logic [WordW-1:0] plen;
  } verdict_t;

  class datagram_verdicts;
    bit                 csum_on;
    logic [CountW-1:0]  count;
    logic [WordW-1:0]   sum;
    logic [ByteW-1:0]   hold;
    logic [WordW-1:0]   sport;
    logic [WordW-1:0]   dport;
    logic [WordW-1:0]   len_field;
    bit                 csum_nz;
    verdict_t           awaited_q[$];
    int unsigned        errors;

    function new();
      csum_on   = 1'b1;
      count     = '0;
      sum       = '0;
      hold      = '0;
      sport     = '0;
      dport     = '0;
      len_field = '0;
      csum_nz   = 1'b0;
      errors    = 0;
    endfunction

    // One's-complement 16-bit add with end-around carry.
    static function logic [WordW-1:0] fold_add(input logic [WordW-1:0] a,
                                               input logic [WordW-1:0] b);
      logic [WordW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
    endfunction

    function void set_checksum_enable(input bit on);
      csum_on = on;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    // Advance the datagram state by one accepted byte; a last byte yields a verdict.
    function void note_byte(input logic [ByteW-1:0] b, input bit fin,
                            input logic [AddrW-1:0] src, input logic [AddrW-1:0] dst);
      logic [WordW-1:0] s;
      logic [WordW-1:0] fin_sum;
      verdict_t         v;

      // The first byte seeds the sum with the pseudo-header.
      if (count == '0) begin
        s = fold_add('0, src[31:16]);
        s = fold_add(s, src[15:0]);
        s = fold_add(s, dst[31:16]);
        s = fold_add(s, dst[15:0]);
        s = fold_add(s, UdpProto);
        sum       = s;
        hold      = '0;
        sport     = '0;
        dport     = '0;
        len_field = '0;
        csum_nz   = 1'b0;
      end

      // Header capture by byte position.
      case (count)
        '0:         sport[15:8]     = b;
        IdxSportLo: sport[7:0]      = b;
        IdxDportHi: dport[15:8]     = b;
        IdxDportLo: dport[7:0]      = b;
        IdxLenHi:   len_field[15:8] = b;
        IdxLenLo:   len_field[7:0]  = b;
        IdxCsumHi, IdxCsumLo: begin
          if (b != '0) csum_nz = 1'b1;
        end
        default: ;
      endcase

      // Bytes pair up into big-endian words by the parity of the count.
      if (!count[0]) hold = b;
      else sum = fold_add(sum, {hold, b});

      if (count != CountMax) count = count + 1'b1;

      if (fin) begin
        fin_sum = sum;
        if (count[0]) fin_sum = fold_add(fin_sum, {hold, 8'h00});
        fin_sum = fold_add(fin_sum, count[15:0]);
        v.sport = sport;
        v.dport = dport;
        v.plen  = '0;
        if (count < HdrLen || count > 17'h0FFFF || count != {1'b0, len_field}) begin
          v.status = STAT_LEN_MISMATCH;
        end else if (count == HdrLen) begin
          v.status = STAT_NO_PAYLOAD;
        end else if (csum_on && csum_nz && fin_sum != SumPassed) begin
          v.status = STAT_CSUM_FAILED;
        end else begin
          v.status = STAT_ACCEPTED;
          v.plen   = 16'(count - HdrLen);
        end
        awaited_q.push_back(v);
        count = '0;
      end
    endfunction

    task report_mismatch(input string what);
      errors++;
      if (errors <= 200) $display("%0t: mismatch: %s", $time, what);
    endtask

    // Compare one result transfer with the oldest predicted verdict.
    task check_result(input logic [1:0] status, input logic [WordW-1:0] sp,
                      input logic [WordW-1:0] dp, input logic [WordW-1:0] pl);
      verdict_t want;
      if (awaited_q.size() == 0) begin
        report_mismatch("result transfer with no datagram outstanding");
      end else begin
        want = awaited_q.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
        if (sp !== want.sport)
          report_mismatch($sformatf("source_port %h, predicted %h", sp, want.sport));
        if (dp !== want.dport)
          report_mismatch($sformatf("dest_port %h, predicted %h", dp, want.dport));
        if (pl !== want.plen)
          report_mismatch($sformatf("payload_length %0d, predicted %0d", pl, want.plen));
      end
    endtask
  endclass

endpackage

@@ verif/udp_datagram_receive_checker_tb.sv @@
// Testbench top for the UDP datagram receive checker.
// Drives datagrams with random pacing and back-pressure and checks every verdict.
// Depends on udc_pkg, udc_verdicts_pkg and the udp_datagram_receive_checker RTL.
module udp_datagram_receive_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import udc_pkg::*;
  import udc_verdicts_pkg::*;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 640;

  typedef enum int {CSUM_ZERO, CSUM_GOOD, CSUM_BAD} csum_kind_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  datagram_verdicts verdicts;
  logic [7:0]       frame_q[$];
  int unsigned      items_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      cycles = 0;
  bit               steady = 1'b0;

  udp_datagram_receive_checker u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Cycle counter and run limit.
  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      verdicts.check_result(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16],
                            m_axis_tdata[47:32]);
  end

  // Receiver back-pressure: segments of open, coin-flip, periodic and bursty stalls.
  initial begin : rx_stall
    rx_mode_e    mode;
    int unsigned span;
    int unsigned stall_left;
    m_axis_tready = 1'b0;
    stall_left = 0;
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          RX_OPEN:     m_axis_tready <= 1'b1;
          RX_COIN:     m_axis_tready <= ($urandom_range(0, 1) == 1);
          RX_PERIODIC: m_axis_tready <= (cycles % 4 == 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              m_axis_tready <= 1'b0;
            end else begin
              m_axis_tready <= 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
            end
          end
        endcase
      end
    end
  end

  // Offer one byte from a falling edge and hold it until its transfer.
  task automatic push_byte(input logic [7:0] b, input bit fin, input logic [31:0] src,
                           input logic [31:0] dst);
    if (!steady && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tdata  <= {dst, src, b};
    s_axis_tlast  <= fin;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    verdicts.note_byte(b, fin, src, dst);
    items_sent++;
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
  endtask

  // Build a datagram with the given header and checksum flavor, then send it.
  task automatic send_datagram(input int len, input logic [15:0] len_field,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input csum_kind_e kind, input int fill,
                               input logic [31:0] src, input logic [31:0] dst);
    logic [15:0] acc;
    logic [15:0] good;
    logic [15:0] csum;
    int          i;
    frame_q.delete();
    for (i = 0; i < len; i++) frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    if (len >= 8) begin
      frame_q[0] = sport[15:8];
      frame_q[1] = sport[7:0];
      frame_q[2] = dport[15:8];
      frame_q[3] = dport[7:0];
      frame_q[4] = len_field[15:8];
      frame_q[5] = len_field[7:0];
      frame_q[6] = 8'h00;
      frame_q[7] = 8'h00;
      // Sum over pseudo-header and data with a zero checksum field.
      acc = datagram_verdicts::fold_add(16'h0000, src[31:16]);
      acc = datagram_verdicts::fold_add(acc, src[15:0]);
      acc = datagram_verdicts::fold_add(acc, dst[31:16]);
      acc = datagram_verdicts::fold_add(acc, dst[15:0]);
      acc = datagram_verdicts::fold_add(acc, UdpProto);
      for (i = 0; i < len; i += 2)
        acc = datagram_verdicts::fold_add(acc,
                {frame_q[i], (i + 1 < len) ? frame_q[i + 1] : 8'h00});
      acc  = datagram_verdicts::fold_add(acc, 16'(len));
      good = ~acc;
      if (good == 16'h0000) good = 16'hFFFF;
      case (kind)
        CSUM_GOOD: csum = good;
        CSUM_BAD: begin
          csum = 16'($urandom);
          while (csum == 16'h0000 || csum == good) csum = 16'($urandom);
        end
        default: csum = 16'h0000;
      endcase
      frame_q[6] = csum[15:8];
      frame_q[7] = csum[7:0];
    end
    for (i = 0; i < len; i++)
      push_byte(frame_q[i], i == len - 1, (i == 0) ? src : $urandom,
                (i == 0) ? dst : $urandom);
  endtask

  // Stop offering bytes until every verdict is in and the pipeline is empty.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdicts.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_checksum_enable(input bit on);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= on;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    verdicts.set_checksum_enable(on);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned base;
    int          len;
    int          phase;
    logic [15:0] lf;
    csum_kind_e  kind;

    verdicts      = new();
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    rst_ni        = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: short headers, no payload, address and data extremes, checksum cases.
    send_datagram(1, 16'd1, '0, '0, CSUM_ZERO, -1, 32'hFFFF_FFFF, 32'h0000_0000);
    send_datagram(7, 16'd7, '0, '0, CSUM_ZERO, -1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_datagram(8, 16'd8, 16'hFFFF, 16'h0000, CSUM_GOOD, -1, $urandom, $urandom);
    send_datagram(9, 16'd9, 16'hFFFF, 16'h0000, CSUM_GOOD, 255,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_datagram(10, 16'd10, 16'h0000, 16'hFFFF, CSUM_GOOD, 0, '0, '0);
    send_datagram(12, 16'd12, 16'($urandom), 16'($urandom), CSUM_ZERO, -1,
                  $urandom, $urandom);
    send_datagram(11, 16'd11, 16'($urandom), 16'($urandom), CSUM_BAD, -1,
                  $urandom, $urandom);
    send_datagram(16, 16'd17, 16'($urandom), 16'($urandom), CSUM_GOOD, -1,
                  $urandom, $urandom);
    send_datagram(8, 16'd9, 16'($urandom), 16'($urandom), CSUM_GOOD, -1,
                  $urandom, $urandom);

    // With checking off a bad checksum still passes.
    wait_for_drain();
    write_checksum_enable(1'b0);
    send_datagram(11, 16'd11, 16'($urandom), 16'($urandom), CSUM_BAD, -1,
                  $urandom, $urandom);
    send_datagram(13, 16'd13, 16'($urandom), 16'($urandom), CSUM_GOOD, -1,
                  $urandom, $urandom);
    wait_for_drain();
    write_checksum_enable(1'b1);

    // Random datagrams, mostly well formed, with the setting flipped twice.
    base  = items_sent;
    phase = 0;
    while (items_sent - base < RandomItems) begin
      if (phase == 0 && items_sent - base >= RandomItems / 3) begin
        wait_for_drain();
        write_checksum_enable(1'b0);
        phase = 1;
      end else if (phase == 1 && items_sent - base >= 2 * RandomItems / 3) begin
        wait_for_drain();
        write_checksum_enable(1'b1);
        phase = 2;
      end else if ($urandom_range(0, 9) == 0) begin
        wait_for_drain();
      end
      steady = ($urandom_range(0, 3) == 0);
      pick   = $urandom_range(0, 99);
      kind   = csum_kind_e'($urandom_range(0, 2));
      if (pick < 30) kind = CSUM_GOOD;
      if (pick < 60) begin
        len = $urandom_range(9, 40);
        lf  = 16'(len);
      end else if (pick < 75) begin
        len = $urandom_range(8, 40);
        lf  = 16'($urandom);
        if (lf == 16'(len)) lf = lf + 16'd1;
      end else if (pick < 90) begin
        len = $urandom_range(1, 7);
        lf  = 16'($urandom);
      end else begin
        len = 8;
        lf  = 16'd8;
      end
      send_datagram(len, lf, 16'($urandom), 16'($urandom), kind, -1, $urandom, $urandom);
    end

    wait_for_drain();
    if (verdicts.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
src/udc_pkg.sv
src/udc_in_stage.sv
src/udc_accum.sv
src/udc_verdict.sv
src/udp_datagram_receive_checker.sv
verif/udc_verdicts_pkg.sv
verif/udp_datagram_receive_checker_tb.sv
